/* design/hrp_pkg.sv */
// shared types, constants and character tables of the request header parser
`default_nettype none

package hrp_pkg;

    localparam int METHOD_CAP_DEF = 16;
    localparam int PATH_CAP_DEF   = 256;

    localparam int HLIM_W = 16;
    localparam int BLIM_W = 24;
    localparam int LEN_W  = BLIM_W + 1;

    localparam logic [HLIM_W-1:0] HEADER_LIMIT_RST = 16'd8192;
    localparam logic [BLIM_W-1:0] BODY_LIMIT_RST   = 24'd1048576;
    localparam logic [LEN_W-1:0]  LEN_SAT          = 25'h100_0000;

    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam int CL_NAME_LEN = 15;
    localparam int VER_LEN     = 5;
    localparam int POST_LEN    = 4;

    // configuration register indexes
    localparam logic CFG_HEADER_LIMIT = 1'b0;
    localparam logic CFG_BODY_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        CLS_METHOD,
        CLS_PATH,
        CLS_HEADER,
        CLS_BODY,
        CLS_NONE
    } byte_class_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD,
        ST_TOO_LARGE
    } status_t;

    typedef struct packed {
        byte_class_t       byte_class;
        logic [7:0]        byte_out;
        logic              done_res;
        status_t           status;
        logic              is_post;
        logic [BLIM_W-1:0] body_length;
    } hrp_result_t;

    typedef struct packed {
        logic step;
        logic clear;
        logic line_start;
    } hrp_clen_ctl_t;

    typedef struct packed {
        logic             err;
        logic             found;
        logic [LEN_W-1:0] value;
    } hrp_clen_stat_t;

    function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "P";
            2'd1:    c = "O";
            2'd2:    c = "S";
            2'd3:    c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        logic r;
        r = (b >= "0" && b <= "9");
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/http_request_header_parser.sv */
// top level of the http request header parser: input stage, config and result register
//
// usage
//   s_* channel takes one transaction per received byte or per peer close:
//   s_tuser is the opcode (0 data byte, 1 close), s_tdata the byte.
//   m_* channel gives exactly one result transaction per input transaction,
//   in order; m_tlast marks the result that ends a request, m_tuser tags
//   the byte as method, path, other header, body or ignored.
//   cfg_we/cfg_addr/cfg_data write header_limit (0) and body_limit (1);
//   write them only while no transaction is in flight.
// pipeline
//   an accepted input goes to one input register, then the parse logic
//   feeds the result register, which drives m_tvalid.
//   it takes one byte per cycle while m_tready is high; each byte updates
//   a few small counters and matchers in a single pass.
// reset
//   rst_n clears the valid flags of both registers, the parse state, and
//   sets the limits to 8192 and 1048576; it then waits for the first request byte.
// back-pressure
//   when m_tready is low the result register holds; one more input is
//   held in the input register, then s_tready drops.
`default_nettype none

module http_request_header_parser
    import hrp_pkg::*;
#(
    parameter int METHOD_CAP = METHOD_CAP_DEF,
    parameter int PATH_CAP   = PATH_CAP_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
    input  wire logic              s_tuser,   // [0] opcode
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // [7:0] byte_out, [9:8] status,
                                              // [10] is_post, [34:11] body_length
    output logic [2:0]             m_tuser,   // [2:0] byte_class
    output logic                   m_tlast,   // done_res
    input  wire logic              cfg_we,
    input  wire logic              cfg_addr,
    input  wire logic [BLIM_W-1:0] cfg_data
);

    localparam int OUT_W   = 8 + 2 + 1 + BLIM_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    hrp_result_t       out_res_reg;
    logic [HLIM_W-1:0] header_limit_reg;
    logic [BLIM_W-1:0] body_limit_reg;
    logic              advance;
    hrp_result_t       res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
            out_res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_limit_reg <= HEADER_LIMIT_RST;
            body_limit_reg   <= BODY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_HEADER_LIMIT)
                header_limit_reg <= cfg_data[HLIM_W-1:0];
            else if (cfg_addr == CFG_BODY_LIMIT)
                body_limit_reg <= cfg_data;
        end
    end

    hrp_parse #(
        .METHOD_CAP (METHOD_CAP),
        .PATH_CAP   (PATH_CAP)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .op_close     (in_op_reg),
        .data_byte    (in_byte_reg),
        .header_limit (header_limit_reg),
        .body_limit   (body_limit_reg),
        .res          (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.byte_class;
    assign m_tlast  = out_res_reg.done_res;
    assign m_tdata  = {(TDATA_W - OUT_W)'(0), out_res_reg.body_length, out_res_reg.is_post,
                       out_res_reg.status, out_res_reg.byte_out};

`ifndef SYNTHESIS
    a_too_large_is_post: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && out_res_reg.status == ST_TOO_LARGE) |->
            (out_res_reg.is_post && out_res_reg.body_length == '0))
        else $error("payload too large reported without post or with a length");
`endif

endmodule

`default_nettype wire

/* design/hrp_clen.sv */
// content-length header line matcher and decimal value accumulator
`default_nettype none

module hrp_clen
    import hrp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hrp_clen_ctl_t  ctl,
    input  wire logic [7:0]     data_byte,
    input  wire logic           prev_cr,
    input  wire logic           lf_end,
    output hrp_clen_stat_t      stat
);

    typedef enum logic [1:0] {
        LM_MATCH,
        LM_OTHER,
        LM_SKIP,
        LM_DIGITS
    } lmode_t;

    lmode_t           lmode_reg, lmode_next;
    logic [3:0]       lidx_reg, lidx_next;
    logic             found_reg, found_next;
    logic [LEN_W-1:0] value_reg, value_next;
    logic             err;
    logic [3:0]       digit;
    logic [LEN_W+3:0] prod;

    // ascii digits carry their value in the low nibble
    assign digit = data_byte[3:0];
    assign prod  = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1)
                 + (LEN_W+4)'(digit);

    always_comb
    begin
        lmode_next = lmode_reg;
        lidx_next  = lidx_reg;
        found_next = found_reg;
        value_next = value_reg;
        err        = 1'b0;
        if (ctl.clear)
        begin
            lmode_next = LM_MATCH;
            lidx_next  = '0;
            found_next = 1'b0;
            value_next = '0;
        end
        else if (ctl.line_start)
        begin
            lmode_next = LM_MATCH;
            lidx_next  = '0;
        end
        else if (ctl.step)
        begin
            case (lmode_reg)
                LM_MATCH:
                begin
                    if (lf_end)
                    begin
                        lidx_next = '0;
                    end
                    else if (lidx_reg < 4'(CL_NAME_LEN) &&
                             to_lower(data_byte) == cl_name_char(lidx_reg))
                    begin
                        lidx_next = lidx_reg + 4'd1;
                        if (lidx_reg == 4'(CL_NAME_LEN - 1))
                        begin
                            if (found_reg)
                                err = 1'b1;
                            else
                                lmode_next = LM_SKIP;
                        end
                    end
                    else
                    begin
                        lmode_next = LM_OTHER;
                    end
                end
                LM_OTHER:
                begin
                    if (lf_end)
                    begin
                        lmode_next = LM_MATCH;
                        lidx_next  = '0;
                    end
                end
                LM_SKIP:
                begin
                    if (is_digit(data_byte))
                    begin
                        lmode_next = LM_DIGITS;
                        value_next = LEN_W'(digit);
                    end
                    else if (data_byte != CH_SP && data_byte != CH_TAB)
                    begin
                        err = 1'b1;
                    end
                end
                LM_DIGITS:
                begin
                    if (prev_cr)
                    begin
                        if (data_byte != CH_LF)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            found_next = 1'b1;
                            lmode_next = LM_MATCH;
                            lidx_next  = '0;
                        end
                    end
                    else if (is_digit(data_byte))
                    begin
                        // saturate just above any body limit
                        if (prod > (LEN_W+4)'(LEN_SAT))
                            value_next = LEN_SAT;
                        else
                            value_next = prod[LEN_W-1:0];
                    end
                    else
                    begin
                        err = (data_byte != CH_CR);
                    end
                end
                default:
                begin
                    lmode_next = lmode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmode_reg <= LM_MATCH;
            lidx_reg  <= '0;
            found_reg <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            lmode_reg <= lmode_next;
            lidx_reg  <= lidx_next;
            found_reg <= found_next;
            value_reg <= value_next;
        end
    end

    assign stat.err   = err;
    assign stat.found = found_reg;
    assign stat.value = value_reg;

`ifndef SYNTHESIS
    a_skip_after_full_name: assert property (@(posedge clk) disable iff (!rst_n)
        (lmode_reg == LM_SKIP) |-> (lidx_reg == 4'(CL_NAME_LEN)))
        else $error("value skip entered without a full header name match");

    a_value_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |=> (value_reg <= LEN_SAT))
        else $error("content length value above saturation point");
`endif

endmodule

`default_nettype wire

/* design/hrp_parse.sv */
// request line and header phase tracking, body countdown and result formation
`default_nettype none

module hrp_parse
    import hrp_pkg::*;
#(
    parameter int METHOD_CAP = METHOD_CAP_DEF,
    parameter int PATH_CAP   = PATH_CAP_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              op_close,
    input  wire logic [7:0]        data_byte,
    input  wire logic [HLIM_W-1:0] header_limit,
    input  wire logic [BLIM_W-1:0] body_limit,
    output hrp_result_t            res
);

    localparam int CAP_MAX = (PATH_CAP > METHOD_CAP) ? PATH_CAP : METHOD_CAP;
    localparam int SEG_MAX = (CAP_MAX > VER_LEN) ? CAP_MAX : VER_LEN;
    localparam int SEG_W   = $clog2(SEG_MAX + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_LINEREST,
        PH_HEADERS,
        PH_BODY,
        PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        CM_NONE,
        CM_CR,
        CM_CRLF,
        CM_CRLFCR,
        CM_END
    } crlf_t;

    phase_t            phase_reg, phase_next, ph_cur;
    crlf_t             crlf_reg, crlf_next;
    logic [HLIM_W-1:0] hcount_reg, hcount_next;
    logic [SEG_W-1:0]  seg_reg, seg_next, seg_inc;
    logic              post_prefix_reg, post_prefix_next;
    logic              is_post_reg, is_post_next;
    logic              prev_cr_reg, prev_cr_next;
    logic [BLIM_W-1:0] remaining_reg, remaining_next;
    logic              lf_end;
    logic              bad;
    hrp_clen_ctl_t     clen_ctl;
    hrp_clen_stat_t    clen_stat;

    assign lf_end  = (data_byte == CH_LF) && prev_cr_reg;
    assign seg_inc = seg_reg + SEG_W'(1);

    always_comb
    begin
        clen_ctl.clear      = step && op_close;
        clen_ctl.step       = step && !op_close && phase_reg == PH_HEADERS && is_post_reg;
        clen_ctl.line_start = step && !op_close && phase_reg == PH_LINEREST && lf_end;
    end

    hrp_clen u_clen (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (clen_ctl),
        .data_byte (data_byte),
        .prev_cr   (prev_cr_reg),
        .lf_end    (lf_end),
        .stat      (clen_stat)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        crlf_next        = crlf_reg;
        hcount_next      = hcount_reg;
        seg_next         = seg_reg;
        post_prefix_next = post_prefix_reg;
        is_post_next     = is_post_reg;
        prev_cr_next     = prev_cr_reg;
        remaining_next   = remaining_reg;
        ph_cur           = phase_reg;
        bad              = 1'b0;

        res.byte_class  = CLS_NONE;
        res.byte_out    = data_byte;
        res.done_res    = 1'b0;
        res.status      = ST_OK;
        res.is_post     = 1'b0;
        res.body_length = '0;

        if (op_close)
        begin
            res.byte_out = 8'd0;
            if (phase_reg != PH_DRAIN)
            begin
                res.done_res = 1'b1;
                res.status   = ST_BAD;
                res.is_post  = is_post_reg;
            end
            phase_next       = PH_IDLE;
            crlf_next        = CM_NONE;
            hcount_next      = '0;
            seg_next         = '0;
            post_prefix_next = 1'b1;
            is_post_next     = 1'b0;
            prev_cr_next     = 1'b0;
            remaining_next   = '0;
        end
        else if (phase_reg == PH_DRAIN)
        begin
            res.byte_class = CLS_NONE;
        end
        else if (phase_reg == PH_BODY)
        begin
            res.byte_class = CLS_BODY;
            remaining_next = remaining_reg - 1'b1;
            if (remaining_reg == BLIM_W'(1))
            begin
                res.done_res    = 1'b1;
                res.is_post     = is_post_reg;
                res.body_length = clen_stat.value[BLIM_W-1:0];
                phase_next      = PH_DRAIN;
            end
        end
        else
        begin
            ph_cur         = (phase_reg == PH_IDLE) ? PH_METHOD : phase_reg;
            phase_next     = ph_cur;
            res.byte_class = CLS_HEADER;
            hcount_next    = (hcount_reg == '1) ? hcount_reg : hcount_reg + 1'b1;

            if (data_byte == CH_CR)
                crlf_next = (crlf_reg == CM_CRLF) ? CM_CRLFCR : CM_CR;
            else if (data_byte == CH_LF)
                crlf_next = (crlf_reg == CM_CR) ? CM_CRLF :
                            ((crlf_reg == CM_CRLFCR) ? CM_END : CM_NONE);
            else
                crlf_next = CM_NONE;

            case (ph_cur)
                PH_METHOD:
                begin
                    if (data_byte == CH_SP)
                    begin
                        if (seg_reg == '0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            is_post_next = (seg_reg == SEG_W'(POST_LEN)) && post_prefix_reg;
                            seg_next     = '0;
                            phase_next   = PH_PATH;
                        end
                    end
                    else
                    begin
                        res.byte_class = CLS_METHOD;
                        if (lf_end)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            if (seg_reg >= SEG_W'(POST_LEN) ||
                                data_byte != post_char(seg_reg[1:0]))
                                post_prefix_next = 1'b0;
                            seg_next = seg_inc;
                            if (seg_inc >= SEG_W'(METHOD_CAP))
                                bad = 1'b1;
                        end
                    end
                end
                PH_PATH:
                begin
                    if (data_byte == CH_SP)
                    begin
                        if (seg_reg == '0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            seg_next   = '0;
                            phase_next = PH_VERSION;
                        end
                    end
                    else
                    begin
                        res.byte_class = CLS_PATH;
                        if (lf_end)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            seg_next = seg_inc;
                            if (seg_inc >= SEG_W'(PATH_CAP))
                                bad = 1'b1;
                        end
                    end
                end
                PH_VERSION:
                begin
                    if (seg_reg >= SEG_W'(VER_LEN) ||
                        data_byte != ver_char(seg_reg[2:0]))
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        seg_next = seg_inc;
                        if (seg_inc == SEG_W'(VER_LEN))
                            phase_next = PH_LINEREST;
                    end
                end
                PH_LINEREST:
                begin
                    if (lf_end)
                        phase_next = PH_HEADERS;
                end
                default:
                begin
                    bad = is_post_reg && clen_stat.err;
                end
            endcase

            prev_cr_next = (data_byte == CH_CR);

            if (bad)
            begin
                res.byte_class = CLS_NONE;
                res.done_res   = 1'b1;
                res.status     = ST_BAD;
                res.is_post    = is_post_next;
                phase_next     = PH_DRAIN;
            end
            else if (crlf_next == CM_END && phase_next == PH_HEADERS)
            begin
                // the blank line never changes the content-length state,
                // so its registered value is final here
                phase_next = PH_DRAIN;
                if (!is_post_next)
                begin
                    res.done_res = 1'b1;
                end
                else if (!clen_stat.found)
                begin
                    res.byte_class = CLS_NONE;
                    res.done_res   = 1'b1;
                    res.status     = ST_BAD;
                    res.is_post    = 1'b1;
                end
                else if (clen_stat.value > {1'b0, body_limit})
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_TOO_LARGE;
                    res.is_post  = 1'b1;
                end
                else if (clen_stat.value == '0)
                begin
                    res.done_res = 1'b1;
                    res.is_post  = 1'b1;
                end
                else
                begin
                    remaining_next = clen_stat.value[BLIM_W-1:0];
                    phase_next     = PH_BODY;
                end
            end
            else if (hcount_next >= header_limit)
            begin
                res.byte_class = CLS_NONE;
                res.done_res   = 1'b1;
                res.status     = ST_BAD;
                res.is_post    = is_post_next;
                phase_next     = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            crlf_reg        <= CM_NONE;
            hcount_reg      <= '0;
            seg_reg         <= '0;
            post_prefix_reg <= 1'b1;
            is_post_reg     <= 1'b0;
            prev_cr_reg     <= 1'b0;
            remaining_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            crlf_reg        <= crlf_next;
            hcount_reg      <= hcount_next;
            seg_reg         <= seg_next;
            post_prefix_reg <= post_prefix_next;
            is_post_reg     <= is_post_next;
            prev_cr_reg     <= prev_cr_next;
            remaining_reg   <= remaining_next;
        end
    end

`ifndef SYNTHESIS
    a_body_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (remaining_reg != '0))
        else $error("body phase with no bytes remaining");

    a_body_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (is_post_reg && clen_stat.found))
        else $error("body phase without a post and a content length");
`endif

endmodule

`default_nettype wire

/* test/http_request_header_parser_test.sv */
// self-checking testbench of the http request header parser with a byte-level parse predictor
`timescale 1ns / 100ps

module http_request_header_parser_test;
    import hrp_pkg::*;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    localparam int CLEN_LEN = 15;
    localparam logic [8*CLEN_LEN-1:0] CLEN_NAME = "content-length:";
    localparam logic [39:0] VER_TAG  = "HTTP/";
    localparam logic [31:0] POST_TAG = "POST";
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_LINEREST,
        PH_HEADERS,
        PH_BODY,
        PH_DRAIN
    } req_phase_t;

    typedef enum logic [1:0] {
        LM_MATCH,
        LM_OTHER,
        LM_SKIP,
        LM_DIGITS
    } line_mode_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;
    logic              s_tuser  = OP_DATA;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_we   = 1'b0;
    logic              cfg_addr = CFG_HEADER_LIMIT;
    logic [BLIM_W-1:0] cfg_data = '0;

    // predicted parser state
    req_phase_t        req_phase;
    int unsigned       hdr_count;
    int unsigned       seg_len;
    logic              post_pfx;
    logic              post_seen;
    int unsigned       crlf_run;
    logic              prev_cr;
    line_mode_t        lmode;
    int unsigned       name_idx;
    logic              clen_found;
    int unsigned       clen_value;
    int unsigned       body_left;
    logic [HLIM_W-1:0] hlim;
    logic [BLIM_W-1:0] blim;

    hrp_result_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int corrupt_pm     = 0;
    int n_errors       = 0;
    int n_checked      = 0;
    int n_parsed       = 0;
    int n_ok           = 0;
    int n_bad          = 0;
    int n_large        = 0;
    int n_body         = 0;

    http_request_header_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("http_request_header_parser_test NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic hrp_result_t make_result(input byte_class_t c, input logic [7:0] b,
                                                input logic d, input status_t s,
                                                input logic p, input logic [BLIM_W-1:0] len);
        hrp_result_t r;
        r.byte_class  = c;
        r.byte_out    = b;
        r.done_res    = d;
        r.status      = s;
        r.is_post     = p;
        r.body_length = len;
        return r;
    endfunction

    function automatic void start_connection();
        req_phase  = PH_IDLE;
        hdr_count  = 0;
        seg_len    = 0;
        post_pfx   = 1'b1;
        post_seen  = 1'b0;
        crlf_run   = 0;
        prev_cr    = 1'b0;
        lmode      = LM_MATCH;
        name_idx   = 0;
        clen_found = 1'b0;
        clen_value = 0;
        body_left  = 0;
    endfunction

    // content-length tracking on header lines of a post, returns 1 on a malformed line
    function automatic logic clen_line_error(input logic [7:0] b, input logic lf_end);
        logic [7:0] lc;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        case (lmode)
            LM_MATCH:
            begin
                if (lf_end)
                begin
                    name_idx = 0;
                    return 1'b0;
                end
                if (name_idx < CLEN_LEN && lc == CLEN_NAME[8*(CLEN_LEN-1-name_idx) +: 8])
                begin
                    name_idx++;
                    if (name_idx == CLEN_LEN)
                    begin
                        if (clen_found)
                            return 1'b1;
                        lmode = LM_SKIP;
                    end
                end
                else
                    lmode = LM_OTHER;
                return 1'b0;
            end
            LM_OTHER:
            begin
                if (lf_end)
                begin
                    lmode    = LM_MATCH;
                    name_idx = 0;
                end
                return 1'b0;
            end
            LM_SKIP:
            begin
                if (b == CH_SP || b == CH_TAB)
                    return 1'b0;
                if (b >= "0" && b <= "9")
                begin
                    lmode      = LM_DIGITS;
                    clen_value = b - "0";
                    return 1'b0;
                end
                return 1'b1;
            end
            default:
            begin
                if (prev_cr)
                begin
                    if (b != CH_LF)
                        return 1'b1;
                    clen_found = 1'b1;
                    lmode      = LM_MATCH;
                    name_idx   = 0;
                    return 1'b0;
                end
                if (b >= "0" && b <= "9")
                begin
                    clen_value = clen_value * 10 + b - "0";
                    if (clen_value > LEN_SAT)
                        clen_value = LEN_SAT;
                    return 1'b0;
                end
                return b != CH_CR;
            end
        endcase
    endfunction

    function automatic hrp_result_t parse_byte(input logic op, input logic [7:0] b);
        hrp_result_t r;
        byte_class_t cls;
        logic        bad;
        logic        lf_end;
        cls = CLS_HEADER;
        bad = 1'b0;
        if (op == OP_CLOSE)
        begin
            if (req_phase == PH_DRAIN)
                r = make_result(CLS_NONE, 8'h00, 1'b0, ST_OK, 1'b0, '0);
            else
                r = make_result(CLS_NONE, 8'h00, 1'b1, ST_BAD, post_seen, '0);
            start_connection();
            return r;
        end
        if (req_phase == PH_DRAIN)
            return make_result(CLS_NONE, b, 1'b0, ST_OK, 1'b0, '0);
        if (req_phase == PH_BODY)
        begin
            body_left--;
            if (body_left == 0)
            begin
                req_phase = PH_DRAIN;
                return make_result(CLS_BODY, b, 1'b1, ST_OK, post_seen, clen_value[BLIM_W-1:0]);
            end
            return make_result(CLS_BODY, b, 1'b0, ST_OK, 1'b0, '0);
        end

        if (req_phase == PH_IDLE)
            req_phase = PH_METHOD;
        hdr_count++;
        lf_end = (b == CH_LF) && prev_cr;

        if (b == CH_CR)
            crlf_run = (crlf_run == 2) ? 3 : 1;
        else if (b == CH_LF)
            crlf_run = (crlf_run == 1) ? 2 : ((crlf_run == 3) ? 4 : 0);
        else
            crlf_run = 0;

        case (req_phase)
            PH_METHOD:
            begin
                if (b == CH_SP)
                begin
                    if (seg_len == 0)
                        bad = 1'b1;
                    else
                    begin
                        post_seen = (seg_len == 4) && post_pfx;
                        seg_len   = 0;
                        req_phase = PH_PATH;
                    end
                end
                else
                begin
                    cls = CLS_METHOD;
                    if (lf_end)
                        bad = 1'b1;
                    else
                    begin
                        if (seg_len >= 4)
                            post_pfx = 1'b0;
                        else if (b != POST_TAG[8*(3-seg_len) +: 8])
                            post_pfx = 1'b0;
                        seg_len++;
                        if (seg_len >= METHOD_CAP_DEF)
                            bad = 1'b1;
                    end
                end
            end
            PH_PATH:
            begin
                if (b == CH_SP)
                begin
                    if (seg_len == 0)
                        bad = 1'b1;
                    else
                    begin
                        seg_len   = 0;
                        req_phase = PH_VERSION;
                    end
                end
                else
                begin
                    cls = CLS_PATH;
                    if (lf_end)
                        bad = 1'b1;
                    else
                    begin
                        seg_len++;
                        if (seg_len >= PATH_CAP_DEF)
                            bad = 1'b1;
                    end
                end
            end
            PH_VERSION:
            begin
                if (seg_len >= 5)
                    bad = 1'b1;
                else if (b != VER_TAG[8*(4-seg_len) +: 8])
                    bad = 1'b1;
                else
                begin
                    seg_len++;
                    if (seg_len == 5)
                        req_phase = PH_LINEREST;
                end
            end
            PH_LINEREST:
            begin
                if (lf_end)
                begin
                    req_phase = PH_HEADERS;
                    lmode     = LM_MATCH;
                    name_idx  = 0;
                end
            end
            default:
            begin
                if (post_seen)
                    bad = clen_line_error(b, lf_end);
            end
        endcase
        prev_cr = (b == CH_CR);

        if (bad)
        begin
            req_phase = PH_DRAIN;
            return make_result(CLS_NONE, b, 1'b1, ST_BAD, post_seen, '0);
        end
        // blank line reached: the header is complete
        if (crlf_run == 4 && req_phase == PH_HEADERS)
        begin
            req_phase = PH_DRAIN;
            if (!post_seen)
                return make_result(cls, b, 1'b1, ST_OK, 1'b0, '0);
            if (!clen_found)
                return make_result(CLS_NONE, b, 1'b1, ST_BAD, 1'b1, '0);
            if (clen_value > blim)
                return make_result(cls, b, 1'b1, ST_TOO_LARGE, 1'b1, '0);
            if (clen_value == 0)
                return make_result(cls, b, 1'b1, ST_OK, 1'b1, '0);
            body_left = clen_value;
            req_phase = PH_BODY;
            return make_result(cls, b, 1'b0, ST_OK, 1'b0, '0);
        end
        if (hdr_count >= hlim)
        begin
            req_phase = PH_DRAIN;
            return make_result(CLS_NONE, b, 1'b1, ST_BAD, post_seen, '0);
        end
        return make_result(cls, b, 1'b0, ST_OK, 1'b0, '0);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        hrp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, tuser 0x%0h tdata 0x%0h tlast %0b",
                         $time, m_tuser, m_tdata, m_tlast);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                compare_field("byte_class", want.byte_class, m_tuser);
                compare_field("byte_out", want.byte_out, m_tdata[7:0]);
                compare_field("done_res", want.done_res, m_tlast);
                compare_field("status", want.status, m_tdata[9:8]);
                compare_field("is_post", want.is_post, m_tdata[10]);
                compare_field("body_length", want.body_length, m_tdata[34:11]);
                compare_field("tdata padding", 32'd0, m_tdata[39:35]);
            end
        end
    end

    // one input transaction, prediction taken at acceptance
    task automatic push_transaction(input logic op, input logic [7:0] b);
        hrp_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = parse_byte(op, b);
        pending_results.push_back(r);
        if (r.byte_class != CLS_NONE || r.done_res)
            n_parsed++;
        if (r.byte_class == CLS_BODY)
            n_body++;
        if (r.done_res)
        begin
            if (r.status == ST_OK)
                n_ok++;
            else if (r.status == ST_BAD)
                n_bad++;
            else
                n_large++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [HLIM_W-1:0] hl, input logic [BLIM_W-1:0] bl);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_HEADER_LIMIT;
        cfg_data <= {{(BLIM_W-HLIM_W){1'b0}}, hl};
        @(posedge clk);
        cfg_addr <= CFG_BODY_LIMIT;
        cfg_data <= bl;
        @(posedge clk);
        cfg_we <= 1'b0;
        hlim = hl;
        blim = bl;
    endtask

    // request byte: dropped once the request has ended, sometimes corrupted
    task automatic send_req_byte(input logic [7:0] b);
        if (req_phase == PH_DRAIN)
            return;
        if (corrupt_pm != 0 && $urandom_range(999) < corrupt_pm)
            push_transaction(OP_DATA, $urandom_range(255));
        else
            push_transaction(OP_DATA, b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_req_byte(s[i]);
    endtask

    task automatic close_connection();
        push_transaction(OP_CLOSE, $urandom_range(255));
    endtask

    task automatic send_clen_line();
        int i;
        int n;
        int pick;
        logic [7:0] c;
        for (i = 0; i < CLEN_LEN; i++)
        begin
            c = CLEN_NAME[8*(CLEN_LEN-1-i) +: 8];
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - 8'd32;
            send_req_byte(c);
        end
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            send_req_byte($urandom_range(1) ? CH_SP : CH_TAB);
        pick = $urandom_range(99);
        if (pick < 70)
            send_text($sformatf("%0d", $urandom_range(0, 40)));
        else if (pick < 80)
            send_text($sformatf("00%0d", $urandom_range(0, 40)));
        else if (pick < 90)
        begin
            // nine or ten digits, saturates above every body limit
            send_req_byte($urandom_range(49, 57));
            n = $urandom_range(8, 9);
            for (i = 0; i < n; i++)
                send_req_byte($urandom_range(48, 57));
        end
        else
        begin
            case ($urandom_range(2))
                0:       send_text("+5");
                1:       send_text("1a");
                default: send_text("3 ");
            endcase
        end
        send_text("\r\n");
    endtask

    task automatic random_request();
        int kind;
        int n;
        int i;
        int j;
        int n_hdr;
        int cl_at;
        logic want_clen;
        logic cut_body;
        corrupt_pm = ($urandom_range(99) < 70) ? 0 : $urandom_range(5, 40);
        if ($urandom_range(99) < 5)
        begin
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
                push_transaction(OP_DATA, $urandom_range(255));
            close_connection();
            return;
        end
        kind = $urandom_range(99);
        if (kind < 50)
            send_text("POST");
        else if (kind < 72)
            send_text("GET");
        else if (kind < 77)
            send_text("post");
        else if (kind < 82)
            send_text("POSTS");
        else
        begin
            n = $urandom_range(1, 18);
            for (i = 0; i < n; i++)
                send_req_byte($urandom_range(65, 90));
        end
        want_clen = (kind < 50) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 25);
        send_text(" /");
        n = ($urandom_range(99) < 2) ? $urandom_range(250, 260) : $urandom_range(0, 12);
        for (i = 0; i < n; i++)
            send_req_byte($urandom_range(33, 126));
        if ($urandom_range(99) < 4)
            send_text(" HTTP1.1\r\n");
        else
            send_text(" HTTP/1.1\r\n");
        n_hdr = $urandom_range(0, 3);
        cl_at = $urandom_range(0, n_hdr);
        for (i = 0; i <= n_hdr; i++)
        begin
            if (want_clen && i == cl_at)
                send_clen_line();
            if (i < n_hdr)
            begin
                n = $urandom_range(1, 8);
                for (j = 0; j < n; j++)
                    send_req_byte($urandom_range(65, 90) + ($urandom_range(1) ? 32 : 0));
                send_text(": ");
                n = $urandom_range(0, 10);
                for (j = 0; j < n; j++)
                    send_req_byte($urandom_range(32, 126));
                send_text("\r\n");
            end
        end
        if (want_clen && $urandom_range(99) < 5)
            send_clen_line();
        send_text("\r\n");
        cut_body = ($urandom_range(99) < 6);
        while (req_phase == PH_BODY && body_left <= 64 &&
               !(cut_body && $urandom_range(99) < 20))
            push_transaction(OP_DATA, $urandom_range(255));
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            push_transaction(OP_DATA, $urandom_range(255));
        close_connection();
    endtask

    task automatic test_close_handling();
        close_connection();
        send_text("GET / HTTP/1.1\r\n\r\n");
        push_transaction(OP_DATA, "x");
        close_connection();
        send_text("POST /u HTTP/1.1\r\nHost: a\r\n");
        close_connection();
        send_text("POST /b HTTP/1.1\r\nContent-Length: 5\r\n\r\nab");
        close_connection();
    endtask

    task automatic test_request_line();
        int i;
        send_text(" / HTTP/1.1\r\n\r\n");
        close_connection();
        send_text("GET  HTTP/1.1\r\n\r\n");
        close_connection();
        send_text("GET\r\n");
        close_connection();
        send_text("GET /a\r\n");
        close_connection();
        send_text("GET / HTTX/1.1\r\n\r\n");
        close_connection();
        for (i = 0; i < METHOD_CAP_DEF; i++)
            send_req_byte("A");
        close_connection();
        send_text("GET /");
        for (i = 0; i < PATH_CAP_DEF - 1; i++)
            send_req_byte("p");
        close_connection();
        send_text("post / HTTP/1.0\r\n\r\n");
        close_connection();
        send_text("POSTS / HTTP/1.0\r\nContent-Length: 4\r\n\r\n");
        close_connection();
        send_text("GET /");
        send_req_byte(8'h00);
        send_req_byte(8'hff);
        send_text(" HTTP/1.1\r\n\r\n");
        close_connection();
    endtask

    task automatic test_content_length();
        send_text("POST /a HTTP/1.1\r\nContent-Length: 3\r\n\r\nabc");
        close_connection();
        send_text("POST / HTTP/1.1\r\ncontent-LENGTH:\t 0\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nHost: x\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 1\r\nContent-Length: 1\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: +5\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: \r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 12 \r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 1\r\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\n");
        close_connection();
    endtask

    task automatic test_limit_extremes();
        // header ending exactly on the limit passes, one byte less fails
        set_limits(18, 0);
        send_text("GET / HTTP/1.1\r\n\r\n");
        close_connection();
        set_limits(17, 0);
        send_text("GET / HTTP/1.1\r\n\r\n");
        close_connection();
        set_limits(4, 0);
        send_text("GET / HTTP/1.1\r\n\r\n");
        close_connection();
        set_limits(300, 0);
        send_text("POST / HTTP/1.1\r\nContent-Length: 1\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 0\r\n\r\n");
        close_connection();
        set_limits(16'hffff, 24'hffffff);
        send_text("POST / HTTP/1.1\r\nContent-Length: 16777216\r\n\r\n");
        close_connection();
        send_text("POST / HTTP/1.1\r\nContent-Length: 16777215\r\n\r\nxyz");
        close_connection();
        set_limits(200, 10);
        send_text("POST /q HTTP/1.1\r\nContent-Length: 10\r\n\r\n0123456789");
        close_connection();
        send_text("POST /q HTTP/1.1\r\nContent-Length: 11\r\n\r\n");
        close_connection();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
        int goal;
        int reqs;
        logic [HLIM_W-1:0] hl;
        logic [BLIM_W-1:0] bl;
        goal = n_parsed + n_bytes;
        reqs = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (n_parsed < goal)
        begin
            if (reqs % 6 == 0)
            begin
                case ($urandom_range(4))
                    0:       hl = 16'hffff;
                    1:       hl = HEADER_LIMIT_RST;
                    2:       hl = $urandom_range(4, 40);
                    default: hl = $urandom_range(41, 300);
                endcase
                case ($urandom_range(4))
                    0:       bl = 24'hffffff;
                    1:       bl = '0;
                    2:       bl = BODY_LIMIT_RST;
                    default: bl = $urandom_range(0, 40);
                endcase
                set_limits(hl, bl);
            end
            else if ($urandom_range(99) < 4)
                wait_drained();
            random_request();
            reqs++;
        end
    endtask

    initial
    begin
        start_connection();
        hlim = HEADER_LIMIT_RST;
        blim = BODY_LIMIT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_close_handling();
        test_request_line();
        test_content_length();
        test_limit_extremes();
        test_random_traffic(0, 0, 200);
        test_random_traffic(55, 0, 200);
        test_random_traffic(0, 55, 200);
        test_random_traffic(37, 37, 200);
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d requests: %0d ok, %0d bad request, %0d payload too large, %0d body bytes",
                 n_ok + n_bad + n_large, n_ok, n_bad, n_large, n_body);
        $display("%0d result transactions checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("http_request_header_parser_test OK");
        else
            $display("http_request_header_parser_test NOT OK");
        $finish;
    end

endmodule
